// File: sv/lsdb_pkg.sv
// Shared types, register codes and reset values for the lidar scan binner.
package lsdb_pkg;

   // Default bin count for one bank
   localparam int NUM_BINS_DEFAULT = 360;

   // Width of the bank epoch tag kept with every stored bin
   localparam int EPOCH_W = 16;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_RANGE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_RANGE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE_OFFSET = 2'd2;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [15:0] MIN_RANGE_RESET    = 16'd120;
   localparam logic [15:0] MAX_RANGE_RESET    = 16'd3500;
   localparam logic [8:0]  ANGLE_OFFSET_RESET = 9'd180;

   // Request function codes
   localparam logic FUNC_POINT = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // Input request
   typedef struct packed {
      logic        func;
      logic [14:0] angle;
      logic [15:0] distance;
      logic [15:0] quality;
      logic        scan_done;
      logic [31:0] now_time;
      logic [8:0]  bin_sel;
      logic        read_last;
   } req_type;

   // Result of a read request
   typedef struct packed {
      logic [15:0] range_out;
      logic        has_return;
      logic [15:0] intensity_out;
      logic [31:0] start_time;
      logic [31:0] duration_time;
      logic        ready_flag;
   } rsp_type;

   // One stored bin: valid flag, epoch of the bank fill that wrote it, payload
   typedef struct packed {
      logic               valid;
      logic [EPOCH_W-1:0] tag;
      logic [15:0]        range_mm;
      logic [15:0]        intensity;
   } entry_type;

endpackage

// File: sv/lsdb_bin_map.sv
// Angle to bin mapping and range gating for one scan point.
module lsdb_bin_map #(
   parameter int NUM_BINS = lsdb_pkg::NUM_BINS_DEFAULT,
   parameter int BIN_W    = $clog2(NUM_BINS)
) (
   input  logic [14:0]      angle,
   input  logic [15:0]      distance,
   input  logic [15:0]      min_range_mm,
   input  logic [15:0]      max_range_mm,
   input  logic [8:0]       angle_offset,
   output logic [BIN_W-1:0] bin,
   output logic             no_return
);
   import lsdb_pkg::*;

   // Rounded degrees reach at most 512, so 10 bits and a 13 bit work word do
   localparam int DEG_W = 10;
   localparam int RED_W = 13;
   // Shifted subtract steps so that NUM_BINS << steps exceeds any degree value
   localparam int MOD_STEPS = (NUM_BINS > 512) ? 1 : $clog2(1024 / NUM_BINS);

   // Reduce a value below NUM_BINS << MOD_STEPS modulo NUM_BINS by restoring shifted subtracts
   function automatic logic [BIN_W-1:0] mod_bins(input logic [DEG_W-1:0] v);
      logic [RED_W-1:0] r;
      r = RED_W'(v);
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
         if (r >= RED_W'(NUM_BINS << k)) begin
            r = r - RED_W'(NUM_BINS << k);
         end
      end
      return r[BIN_W-1:0];
   endfunction

   logic [15:0]      angle_rnd;
   logic [DEG_W-1:0] deg;
   logic [BIN_W-1:0] deg_bin;
   logic [BIN_W-1:0] off_bin;
   logic [BIN_W:0]   diff;

   // Round the angle to whole degrees
   assign angle_rnd = {1'b0, angle} + 16'd32;
   assign deg       = angle_rnd[15:6];

   // Fold degree and offset into the bin range
   assign deg_bin = mod_bins(deg);
   assign off_bin = mod_bins({1'b0, angle_offset});

   // Reverse direction: offset minus angle, wrapped once
   assign diff = {1'b0, off_bin} + (BIN_W+1)'(NUM_BINS) - {1'b0, deg_bin};
   assign bin  = (diff >= (BIN_W+1)'(NUM_BINS)) ? BIN_W'(diff - (BIN_W+1)'(NUM_BINS))
                                                : diff[BIN_W-1:0];

   // Gate the distance against the configured window
   assign no_return = (distance == 16'd0) || (distance < min_range_mm)
                      || (distance > max_range_mm);

endmodule

// File: sv/lsdb_bin_ram.sv
// Bin memory for both banks with a clearing sweep after reset.
module lsdb_bin_ram #(
   parameter int DEPTH  = 2 * lsdb_pkg::NUM_BINS_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  lsdb_pkg::entry_type   wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output lsdb_pkg::entry_type   rd_data,
   output logic                  busy
);
   import lsdb_pkg::*;

   entry_type         mem [DEPTH];
   entry_type         rd_data_ff;
   logic              busy_ff;
   logic              busy_in;
   logic [ADDR_W-1:0] ptr_ff;
   logic [ADDR_W-1:0] ptr_in;

   // Advance the clearing pointer until every entry has been written once
   always_comb begin
      busy_in = busy_ff;
      ptr_in  = ptr_ff;
      if (busy_ff) begin
         ptr_in = ptr_ff + ADDR_W'(1);
         if (ptr_ff == ADDR_W'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         ptr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         ptr_ff  <= ptr_in;
      end
   end

   // Write port: sweep first, then requests; registered read port
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[ptr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

// File: sv/lidar_scan_double_buffer_binner.sv
// Top level of the double-buffered lidar scan binner.
//
// Accepts one request per cycle, point or read, with no bubbles between them,
// as long as a waiting read result is taken. A request's bin is computed in
// the input register, where the bin memory is written (points) or read
// (reads); a read's result is in the result register on the next cycle.
// The memory has a single write port and a registered read port. Bank
// switching on the end-of-scan mark clears the new fill bank at once by
// bumping that bank's epoch tag, so no clearing sweep follows a scan.
// After reset the block sweeps all 2*NUM_BINS memory entries once and takes
// no request until the sweep ends; configuration writes are taken throughout.
// Configuration is meant to be written while no request is in flight.
module lidar_scan_double_buffer_binner #(
   parameter int NUM_BINS = lsdb_pkg::NUM_BINS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lsdb_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lsdb_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lsdb_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lsdb_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import lsdb_pkg::*;

   localparam int BIN_W  = $clog2(NUM_BINS);
   localparam int DEPTH  = 2 * NUM_BINS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SEL_W  = 13;

   // Configuration registers
   logic [15:0] min_range_ff;
   logic [15:0] max_range_ff;
   logic [8:0]  angle_offset_ff;

   // Input register
   logic    s1_valid_ff;
   req_type s1_req_ff;

   // Result register
   logic               s2_valid_ff;
   logic               s2_sel_ok_ff;
   logic [EPOCH_W-1:0] s2_epoch_ff;
   logic [31:0]        s2_start_ff;
   logic [31:0]        s2_duration_ff;
   logic               s2_ready_flag_ff;

   // Bank state
   logic               fill_bank_ff;
   logic               published_bank_ff;
   logic               scan_pending_ff;
   logic [31:0]        bank_start_ff    [2];
   logic [31:0]        bank_duration_ff [2];
   logic [EPOCH_W-1:0] epoch_ff         [2];

   logic             req_accept;
   logic             s1_go;
   logic             s1_point;
   logic             s1_read;
   logic             s2_load;
   logic             ram_busy;
   logic [BIN_W-1:0] point_bin;
   logic             point_no_return;
   logic             sel_ok;
   logic [BIN_W-1:0] sel_bin;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [ADDR_W-1:0] rd_addr;
   entry_type        rd_data;
   logic             hit;
   logic             fill_nxt;

   // Take register writes at any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff    <= MIN_RANGE_RESET;
         max_range_ff    <= MAX_RANGE_RESET;
         angle_offset_ff <= ANGLE_OFFSET_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MIN_RANGE:    min_range_ff    <= csr_wdata;
            REG_MAX_RANGE:    max_range_ff    <= csr_wdata;
            REG_ANGLE_OFFSET: angle_offset_ff <= csr_wdata[8:0];
            default:          ;
         endcase
      end
   end

   // Advance a point always; advance a read when the result register frees up
   assign s1_point   = s1_valid_ff && (s1_req_ff.func == FUNC_POINT);
   assign s1_read    = s1_valid_ff && (s1_req_ff.func == FUNC_READ);
   assign s1_go      = s1_point || (s1_read && (!s2_valid_ff || rsp_ready));
   assign s2_load    = s1_go && s1_read;
   assign req_ready  = !ram_busy && (!s1_valid_ff || s1_go);
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
      end
   end

   // Map the point to its bin
   lsdb_bin_map #(
      .NUM_BINS (NUM_BINS),
      .BIN_W    (BIN_W)
   ) u_bin_map (
      .angle        (s1_req_ff.angle),
      .distance     (s1_req_ff.distance),
      .min_range_mm (min_range_ff),
      .max_range_mm (max_range_ff),
      .angle_offset (angle_offset_ff),
      .bin          (point_bin),
      .no_return    (point_no_return)
   );

   // Build the point write into the fill bank
   assign wr_en   = s1_point;
   assign wr_addr = fill_bank_ff ? ADDR_W'(point_bin) + ADDR_W'(NUM_BINS)
                                 : ADDR_W'(point_bin);
   always_comb begin
      wr_data.valid     = !point_no_return;
      wr_data.tag       = epoch_ff[fill_bank_ff];
      wr_data.range_mm  = s1_req_ff.distance;
      wr_data.intensity = s1_req_ff.quality;
   end

   // Build the read address into the published bank
   assign sel_ok  = SEL_W'(s1_req_ff.bin_sel) < SEL_W'(NUM_BINS);
   assign sel_bin = sel_ok ? BIN_W'(s1_req_ff.bin_sel) : '0;
   assign rd_addr = published_bank_ff ? ADDR_W'(sel_bin) + ADDR_W'(NUM_BINS)
                                      : ADDR_W'(sel_bin);

   lsdb_bin_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_bin_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (s2_load),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .busy    (ram_busy)
   );

   // Switch banks on the end-of-scan mark; drop the ready flag on a last read
   assign fill_nxt = !fill_bank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_bank_ff        <= 1'b0;
         published_bank_ff   <= 1'b0;
         scan_pending_ff     <= 1'b0;
         bank_start_ff[0]    <= '0;
         bank_start_ff[1]    <= '0;
         bank_duration_ff[0] <= '0;
         bank_duration_ff[1] <= '0;
         epoch_ff[0]         <= '0;
         epoch_ff[1]         <= '0;
      end else if (s1_point && s1_req_ff.scan_done) begin
         bank_duration_ff[fill_bank_ff] <= s1_req_ff.now_time - bank_start_ff[fill_bank_ff];
         published_bank_ff              <= fill_bank_ff;
         fill_bank_ff                   <= fill_nxt;
         epoch_ff[fill_nxt]             <= epoch_ff[fill_nxt] + EPOCH_W'(1);
         bank_start_ff[fill_nxt]        <= s1_req_ff.now_time;
         scan_pending_ff                <= 1'b1;
      end else if (s2_load && s1_req_ff.read_last) begin
         scan_pending_ff <= 1'b0;
      end
   end

   // Hold the read result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load) begin
         s2_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_sel_ok_ff     <= sel_ok;
         s2_epoch_ff      <= epoch_ff[published_bank_ff];
         s2_start_ff      <= bank_start_ff[published_bank_ff];
         s2_duration_ff   <= bank_duration_ff[published_bank_ff];
         s2_ready_flag_ff <= scan_pending_ff;
      end
   end

   // A bin counts only if written during the published bank's current fill
   assign hit = s2_sel_ok_ff && rd_data.valid && (rd_data.tag == s2_epoch_ff);

   assign rsp_valid = s2_valid_ff;
   always_comb begin
      rsp_data.range_out     = hit ? rd_data.range_mm : 16'd0;
      rsp_data.has_return    = hit;
      rsp_data.intensity_out = hit ? rd_data.intensity : 16'd0;
      rsp_data.start_time    = s2_start_ff;
      rsp_data.duration_time = s2_duration_ff;
      rsp_data.ready_flag    = s2_ready_flag_ff;
   end

   // No request enters while the memory sweep runs
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      ram_busy |-> !req_ready)
      else $error("request accepted during memory sweep");

   // A stalled result is never overwritten by a read moving up
   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !rsp_ready) |-> !s2_load)
      else $error("read result overwritten while stalled");

   // End of scan publishes the bank just filled and moves to the other one
   a_bank_switch: assert property (@(posedge clock) disable iff (reset)
      (s1_point && s1_req_ff.scan_done) |=>
         (published_bank_ff == $past(fill_bank_ff))
         && (fill_bank_ff != $past(fill_bank_ff)))
      else $error("bank switch on end of scan went wrong");

   // A bin with a return always carries a nonzero distance
   a_return_has_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.has_return) |-> (rsp_data.range_out != 16'd0))
      else $error("return reported with zero range");

endmodule
